// ===== hdl/integer_to_radix_digits_defines.svh =====
// Assertion helpers for the radix digit converter.
// Both forms sample on clk and are disabled while rst is high.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS

`define ITRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ITRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ITRD_ASSERT_IMP(label, ante, cons)

`define ITRD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/itrd_pkg.sv =====
package itrd_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int SYM_COUNT_W = 5;
  localparam int DIGIT_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam int MAX_SYMBOLS    = 16;
  localparam int MAX_DIGITS_DEF = 32;

  // quotient bits resolved per cycle and division steps per digit
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int PHASE_W   = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic load_value;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic alph_ok;
    logic negative;
    logic div_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== hdl/itrd_ram.sv =====
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/itrd_dp.sv =====
`include "integer_to_radix_digits_defines.svh"

module itrd_dp import itrd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [VALUE_W-1:0] value,
  input  cmd_t                      cmd,
  output status_t                   st,
  output logic                      char_valid,
  input  logic                      char_stall,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      last,
  output logic                      alphabet_error
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [SYM_COUNT_W-1:0] symbol_count;
  logic [CFG_DATA_W-1:0]  symbols_low;
  logic [CFG_DATA_W-1:0]  symbols_high;

  logic [CHAR_W*MAX_SYMBOLS-1:0] sym_bits;
  logic [CHAR_W-1:0]             sym [MAX_SYMBOLS];
  logic                          alph_ok;

  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] mag_next;
  logic [VALUE_W-1:0] value_u;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [DIV_BITS-1:0] qbits;
  logic               negative;
  logic [PHASE_W-1:0] phase;
  logic               phase_last;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      rd_idx_next;
  logic [DIGIT_W-1:0] rdata;
  logic               digit_we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SYMBOL_COUNT: symbol_count <= cfg_data[SYM_COUNT_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sym_bits = {symbols_high, symbols_low};

  // alphabet check: symbol count range, no sign characters, pairwise compare over the used symbols
  always_comb begin
    alph_ok = (symbol_count >= SYM_COUNT_W'(2)) &&
              (symbol_count <= SYM_COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sym[i] = sym_bits[CHAR_W*i +: CHAR_W];
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (SYM_COUNT_W'(i) < symbol_count) begin
        if (sym[i] == CH_PLUS || sym[i] == CH_MINUS) begin
          alph_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (sym[j] == sym[i]) begin
            alph_ok = 1'b0;
          end
        end
      end
    end
  end

  assign value_u = value;

  // restoring division by the radix, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0] r;
    logic [DIGIT_W:0] r_sh;
    r     = {1'b0, rem};
    qbits = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      r_sh = {r[DIGIT_W-1:0], mag[VALUE_W-1-k]};
      if (r_sh >= symbol_count) begin
        r                    = r_sh - symbol_count;
        qbits[DIV_BITS-1-k]  = 1'b1;
      end else begin
        r = r_sh;
      end
    end
    rem_next = r[DIGIT_W-1:0];
    mag_next = {mag[VALUE_W-DIV_BITS-1:0], qbits};
  end

  assign phase_last = (phase == PHASE_W'(DIV_STEPS - 1));
  assign digit_we   = cmd.div_step && phase_last;

  always_comb begin
    rd_idx_next = rd_idx;
    if (digit_we) begin
      rd_idx_next = count[AW-1:0];
    end else if (cmd.emit_digit && rd_idx != '0) begin
      rd_idx_next = rd_idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      phase  <= '0;
      rd_idx <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      if (cmd.load_value) begin
        count <= '0;
        phase <= '0;
      end else if (cmd.div_step) begin
        phase <= phase + PHASE_W'(1);
        if (phase_last) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_value) begin
      negative <= value_u[VALUE_W-1];
      mag      <= value_u[VALUE_W-1] ? ('0 - value_u) : value_u;
      rem      <= '0;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      rem <= phase_last ? '0 : rem_next;
    end
  end

  itrd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk  (clk),
    .we   (digit_we),
    .waddr(count[AW-1:0]),
    .wdata(rem_next),
    .raddr(rd_idx_next),
    .rdata(rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_err) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char       <= CH_MINUS;
      last           <= 1'b0;
      alphabet_error <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char       <= sym[rdata];
      last           <= (rd_idx == '0);
      alphabet_error <= 1'b0;
    end else if (cmd.emit_err) begin
      out_char       <= '0;
      last           <= 1'b1;
      alphabet_error <= 1'b1;
    end
  end

  assign st.alph_ok   = alph_ok;
  assign st.negative  = negative;
  assign st.div_done  = phase_last &&
                        ((mag_next == '0) || (count + CW'(1) == CW'(MAX_DIGITS)));
  assign st.out_free  = !char_valid || !char_stall;
  assign st.emit_last = (rd_idx == '0);

  `ITRD_ASSERT_IMP(a_rem_below_radix, digit_we, ({1'b0, rem_next} < symbol_count))
  `ITRD_ASSERT_IMP(a_read_in_range, cmd.emit_digit, ({1'b0, rd_idx} < count))

endmodule

// ===== hdl/itrd_ctrl.sv =====
`include "integer_to_radix_digits_defines.svh"

module itrd_ctrl import itrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    value_valid,
  output logic    value_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ERR  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign value_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (value_valid) begin
          if (st.alph_ok) begin
            cmd.load_value = 1'b1;
            state_next     = ST_DIV;
          end else begin
            state_next = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        // also lets the last digit write settle before the first read
        if (!st.negative) begin
          state_next = ST_EMIT;
        end else if (st.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          if (st.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (st.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ITRD_ASSERT_IMP(a_emit_needs_room, (cmd.emit_sign || cmd.emit_digit || cmd.emit_err), st.out_free)
  `ITRD_ASSERT_NEXT(a_accept_to_div, (state == ST_IDLE && value_valid && st.alph_ok), (state == ST_DIV))

endmodule

// ===== hdl/integer_to_radix_digits.sv =====
// One value per conversion; the next value is taken once the last beat is in the output register.
// Each digit is one full division of the 32-bit magnitude by the shared divider, 8 quotient bits per cycle.
// Beats follow at one per cycle when not stalled; a minus sign, if any, comes before the digits.
// rst (sync, active high) clears config, control, counters and output valid; data regs and digit memory are not.
module integer_to_radix_digits import itrd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      value_valid,
  output logic                      value_stall,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      char_valid,
  input  logic                      char_stall,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      last,
  output logic                      alphabet_error
);

  cmd_t    cmd;
  status_t st;

  itrd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .st         (st),
    .cmd        (cmd)
  );

  itrd_dp #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .value         (value),
    .cmd           (cmd),
    .st            (st),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .out_char      (out_char),
    .last          (last),
    .alphabet_error(alphabet_error)
  );

endmodule

// ===== verif/tb_top.sv =====
module tb_top import itrd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int ITEM_TARGET  = 230;
  localparam int QUIET_AFTER  = 195;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } char_beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_SYMBOL_COUNT;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      value_valid = 1'b0;
  logic                      value_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      char_valid;
  logic                      char_stall = 1'b0;
  logic [CHAR_W-1:0]         out_char;
  logic                      last;
  logic                      alphabet_error;

  // local copy of the configuration
  logic [SYM_COUNT_W-1:0] sym_count = '0;
  logic [63:0]            sym_lo = '0;
  logic [63:0]            sym_hi = '0;

  char_beat_t expected_chars[$];
  char_beat_t want;

  int  mismatches = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  int  error_beats = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  src_bursty = 1'b1;
  bit  sink_bursty = 1'b1;

  integer_to_radix_digits u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .value_valid    (value_valid),
    .value_stall    (value_stall),
    .value          (value),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .out_char       (out_char),
    .last           (last),
    .alphabet_error (alphabet_error)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_chars.size());
      $display("integer_to_radix_digits regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit alphabet_valid();
    logic [127:0] a;
    int           n;
    a = {sym_hi, sym_lo};
    n = int'(sym_count);
    if (n < 2 || n > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (a[i*8 +: 8] == CH_PLUS || a[i*8 +: 8] == CH_MINUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (a[j*8 +: 8] == a[i*8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void convert_value(logic [VALUE_W-1:0] v);
    logic [127:0]       a;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digs [32];
    int                 n;
    logic [VALUE_W-1:0] radix;
    a = {sym_hi, sym_lo};
    if (!alphabet_valid()) begin
      expected_chars.push_back('{ch: '0, last: 1'b1, err: 1'b1});
      return;
    end
    radix = VALUE_W'(sym_count);
    // unsigned negation keeps the most negative value intact
    mag = v[VALUE_W-1] ? VALUE_W'(32'd0 - v) : v;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % radix);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < MAX_DIGITS_DEF);
    if (v[VALUE_W-1])
      expected_chars.push_back('{ch: CH_MINUS, last: 1'b0, err: 1'b0});
    for (int i = n; i > 0; i--)
      expected_chars.push_back('{ch: a[int'(digs[i-1])*8 +: 8], last: (i == 1), err: 1'b0});
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) begin
      beats_seen++;
      if (alphabet_error) error_beats++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: char=%02h last=%0b err=%0b",
                                  out_char, last, alphabet_error));
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch || last !== want.last || alphabet_error !== want.err)
          report_mismatch($sformatf(
            "beat mismatch: exp char=%02h last=%0b err=%0b, got char=%02h last=%0b err=%0b",
            want.ch, want.last, want.err, out_char, last, alphabet_error));
      end
    end
  end

  // ---------------------------------------------------------------- output stall

  always @(negedge clk) begin
    if (!sink_bursty) begin
      char_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      char_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      char_stall <= 1'b1;
    end else begin
      char_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      REG_SYMBOL_COUNT: sym_count = data[SYM_COUNT_W-1:0];
      REG_SYMBOLS_LOW:  sym_lo = data;
      REG_SYMBOLS_HIGH: sym_hi = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // symbol_count write carries junk above the 5 bits in use
  task automatic program_alphabet(int count, logic [127:0] a);
    logic [CFG_DATA_W-1:0] cnt_word;
    cnt_word = {$urandom, $urandom};
    cnt_word[SYM_COUNT_W-1:0] = SYM_COUNT_W'(count);
    write_reg(REG_SYMBOL_COUNT, cnt_word);
    write_reg(REG_SYMBOLS_LOW, a[63:0]);
    write_reg(REG_SYMBOLS_HIGH, a[127:64]);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    value_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // valid is left high after the beat; a pause or drain() lowers it
  task automatic send_value(logic [VALUE_W-1:0] v);
    if (src_bursty && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 18));
    convert_value(v);
    @(negedge clk);
    value_valid <= 1'b1;
    value       <= v;
    items_sent++;
    do @(posedge clk); while (value_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    value_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [127:0] random_alphabet(int count);
    logic [127:0] a;
    logic [7:0]   b;
    bit           clash;
    a = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < count && i < MAX_SYMBOLS; i++) begin
      do begin
        b = 8'($urandom_range(0, 255));
        clash = (b == CH_PLUS || b == CH_MINUS);
        for (int j = 0; j < i; j++)
          if (a[j*8 +: 8] == b) clash = 1'b1;
      end while (clash);
      a[i*8 +: 8] = b;
    end
    return a;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(int radix);
    longint p;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = VALUE_W'($urandom_range(0, 40));
      1: case ($urandom_range(0, 3))
           0: v = 32'h8000_0000;
           1: v = 32'h7FFF_FFFF;
           2: v = 32'h0000_0000;
           default: v = 32'hFFFF_FFFF;
         endcase
      2: begin
        // around a power of the radix, where the digit count changes
        p = 1;
        repeat ($urandom_range(0, 31))
          if (radix >= 2 && p * radix < 64'sh8000_0000) p = p * radix;
        v = VALUE_W'(p - $urandom_range(0, 1));
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 2) == 0) v = VALUE_W'(32'd0 - v);
    return v;
  endfunction

  // ---------------------------------------------------------------- tests

  localparam logic [127:0] DECIMAL = {48'h0, 16'h3938, 64'h3736_3534_3332_3130};

  task automatic test_alphabet_after_reset();
    // all registers still zero: no symbols at all
    send_value(32'd123);
    drain();
  endtask

  task automatic test_decimal_extremes();
    program_alphabet(10, DECIMAL);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    drain();
  endtask

  task automatic test_binary_extremes();
    program_alphabet(2, {112'h0, 16'h3130});
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    drain();
  endtask

  task automatic test_zero_byte_symbol();
    // base 16 with a NUL byte as symbol 0
    program_alphabet(16, {64'h4F4E_4D4C_4B4A_4948, 64'h4746_4544_4342_4100});
    send_value(32'd16);
    send_value(32'd0);
    send_value(-32'sd255);
    drain();
  endtask

  task automatic test_unused_symbol_bytes();
    // sign bytes and a repeat sit beyond the symbols in use
    program_alphabet(3, {64'h7878_2B2D_2B2D_2B2D, 64'h2D2D_2B2B_2B7A_7978});
    send_value(32'd7);
    send_value(-32'sd8);
    drain();
  endtask

  task automatic test_alphabet_errors();
    logic [127:0] hex_alpha;
    logic [127:0] a;
    hex_alpha = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};
    write_reg(REG_SYMBOL_COUNT, 64'h0000_0000_0000_0001);
    send_value(32'd5);
    drain();
    write_reg(REG_SYMBOL_COUNT, 64'hFFFF_FFFF_FFFF_FFF1);
    send_value(32'd5);
    drain();
    write_reg(REG_SYMBOL_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(-32'sd5);
    drain();
    a = DECIMAL;
    a[9*8 +: 8] = CH_PLUS;
    program_alphabet(10, a);
    send_value(32'd42);
    drain();
    a = hex_alpha;
    a[12*8 +: 8] = CH_MINUS;
    program_alphabet(16, a);
    send_value(32'd42);
    drain();
    a = hex_alpha;
    a[15*8 +: 8] = a[0 +: 8];
    program_alphabet(16, a);
    send_value(32'h8000_0000);
    drain();
  endtask

  task automatic test_random_alphabets();
    int           radix;
    int           n_items;
    bit           broken;
    logic [127:0] a;
    int           pos;
    int           src;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_AFTER) begin
        src_bursty  = 1'b0;
        sink_bursty = 1'b0;
      end else begin
        src_bursty  = ($urandom_range(0, 3) != 0);
        sink_bursty = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 3))
        0: radix = 2;
        1: radix = MAX_SYMBOLS;
        default: radix = $urandom_range(2, MAX_SYMBOLS);
      endcase
      a = random_alphabet(radix);
      broken = (items_sent < QUIET_AFTER) && ($urandom_range(0, 4) == 0);
      if (broken) begin
        case ($urandom_range(0, 3))
          0: radix = $urandom_range(0, 1);
          1: radix = $urandom_range(MAX_SYMBOLS + 1, 31);
          2: begin
            pos = $urandom_range(0, radix - 1);
            a[pos*8 +: 8] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
          end
          default: begin
            pos = $urandom_range(1, radix - 1);
            src = $urandom_range(0, pos - 1);
            a[pos*8 +: 8] = a[src*8 +: 8];
          end
        endcase
      end
      program_alphabet(radix, a);
      n_items = broken ? $urandom_range(2, 5) : $urandom_range(10, 25);
      repeat (n_items) send_value(pick_value(radix));
      drain();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_alphabet_after_reset();
    test_decimal_extremes();
    test_binary_extremes();
    test_zero_byte_symbol();
    test_unused_symbol_bytes();
    test_alphabet_errors();
    test_random_alphabets();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d beats (%0d alphabet errors), %0d register writes",
             items_sent, beats_seen, error_beats, cfg_writes);
    $display("radices 2 to 16 plus bad alphabets, under random stalls on both channels");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("integer_to_radix_digits regression: pass");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, expected_chars.size());
      $display("integer_to_radix_digits regression: fail");
    end
    $finish;
  end

endmodule

// ===== integer_to_radix_digits.f =====
+incdir+hdl
hdl/itrd_pkg.sv
hdl/itrd_ram.sv
hdl/itrd_dp.sv
hdl/itrd_ctrl.sv
hdl/integer_to_radix_digits.sv
verif/tb_top.sv
